// File: hdl/sfdx_pkg.sv
// Shared types and constants for the sync frame deframer.
`default_nettype none

package sfdx_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  // Payload: four button bytes and one velocity byte
  localparam int unsigned PAYLOAD_LEN = 5;
  localparam int unsigned POS_W       = 3;
  localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(PAYLOAD_LEN);

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [7:0]       byte_t;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_HALF,
    ST_FRAME
  } state_t;

endpackage

`default_nettype wire

// File: hdl/sync_frame_deframer_xor_check_core.sv
// Channel   | Ports                                   | Direction
// ----------+-----------------------------------------+----------
// input     | in_valid, in_stall, in_rx_byte           | byte in
// result    | out_valid, out_stall, out_frame_status,  | frame out
//           | out_button_a..d, out_note_velocity      |
//
// One byte is taken per cycle while in_stall is low; state register and running
// XOR update in the cycle of the transfer, and a frame result is registered on
// its checksum byte. Synchronous active-low reset returns to sync hunting.
// in_stall is raised only when the next byte is a checksum byte and the
// result register still holds a frame the sink has not taken.
`default_nettype none

module sync_frame_deframer_xor_check_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire sfdx_pkg::byte_t in_rx_byte,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic                out_frame_status,
  output sfdx_pkg::byte_t     out_button_a,
  output sfdx_pkg::byte_t     out_button_b,
  output sfdx_pkg::byte_t     out_button_c,
  output sfdx_pkg::byte_t     out_button_d,
  output sfdx_pkg::byte_t     out_note_velocity
);

  import sfdx_pkg::*;

  state_t state_r, state_nxt;
  pos_t   pos_r, pos_nxt;
  byte_t  xor_r, xor_nxt;
  byte_t  payload_r [PAYLOAD_LEN];

  logic   out_valid_r, out_valid_nxt;
  logic   status_r;
  byte_t  btn_a_r, btn_b_r, btn_c_r, btn_d_r, vel_r;

  logic   in_xfer;
  logic   at_checksum;
  logic   emit;
  logic   store;

  assign at_checksum = (state_r == ST_FRAME) && !(pos_r < POS_CHECKSUM);
  assign in_stall    = at_checksum && out_valid_r && out_stall;
  assign in_xfer     = in_valid && !in_stall;
  assign emit        = in_xfer && at_checksum;
  assign store       = in_xfer && (state_r == ST_FRAME) && (pos_r < POS_CHECKSUM);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    if (in_xfer) begin
      unique case (state_r)
        ST_HUNT: begin
          if (in_rx_byte == SYNC_FIRST) state_nxt = ST_HALF;
        end
        ST_HALF: begin
          if (in_rx_byte == SYNC_SECOND) begin
            state_nxt = ST_FRAME;
            pos_nxt   = '0;
            xor_nxt   = '0;
          end else if (in_rx_byte == SYNC_FIRST) begin
            state_nxt = ST_HALF;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
        ST_FRAME: begin
          if (pos_r < POS_CHECKSUM) begin
            xor_nxt = xor_r ^ in_rx_byte;
            pos_nxt = pos_r + pos_t'(1);
          end else begin
            state_nxt = ST_HUNT;
            pos_nxt   = '0;
            xor_nxt   = '0;
          end
        end
        default: begin
          state_nxt = ST_HUNT;
          pos_nxt   = '0;
          xor_nxt   = '0;
        end
      endcase
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      pos_r       <= '0;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      xor_r       <= xor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      payload_r[pos_r] <= in_rx_byte;
    end
  end

  // Result register loads only on the checksum transfer
  always_ff @(posedge clk) begin
    if (emit) begin
      status_r <= (xor_r != in_rx_byte) ? STATUS_BAD : STATUS_GOOD;
      btn_a_r  <= payload_r[0];
      btn_b_r  <= payload_r[1];
      btn_c_r  <= payload_r[2];
      btn_d_r  <= payload_r[3];
      vel_r    <= payload_r[4];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_status  = status_r;
  assign out_button_a      = btn_a_r;
  assign out_button_b      = btn_b_r;
  assign out_button_c      = btn_c_r;
  assign out_button_d      = btn_d_r;
  assign out_note_velocity = vel_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_CHECKSUM)
    else $error("byte position beyond checksum slot");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_FRAME) |-> (pos_r == '0 && xor_r == '0))
    else $error("position or xor not cleared outside a frame");

  a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && state_r == ST_HUNT))
    else $error("checksum transfer did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit)
    else $error("result overwritten while held");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FRAME && pos_r == POS_CHECKSUM))
    else $error("result raised outside checksum slot");

endmodule

`default_nettype wire
